// ===== design/salc_pkg.sv =====
// salc_pkg: shared constants, codes and control types of the set-associative lru cache
// no dependencies; imported by the interfaces and every module of the block

package salc_pkg;

  localparam int unsigned SETS_LOG2_DEF   = 6;
  localparam int unsigned WAYS_DEF        = 8;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned SET_BITS_W  = 3;
  localparam int unsigned WAYS_CFG_W  = 4;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned OUTCOME_W   = 2;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd6;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST     = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS = 1'b0,
    CFG_WAYS     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_MISS   = 2'd0,
    OUT_UPDATE = 2'd1,
    OUT_HIT    = 2'd2
  } outcome_e;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

// ===== design/salc_in_if.sv =====
// salc_in_if: valid/ready request channel carrying func, key and value
// depends on salc_pkg

interface salc_in_if import salc_pkg::*; #(
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

// ===== design/salc_out_if.sv =====
// salc_out_if: valid/ready result channel carrying outcome, hit_way and miss_count
// depends on salc_pkg

interface salc_out_if import salc_pkg::*; #(
  parameter int unsigned WAY_W = 3
) ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [WAY_W-1:0]     hit_way;
  logic [COUNT_W-1:0]   miss_count;

  modport source (output valid, outcome, hit_way, miss_count, input ready);
  modport sink   (input valid, outcome, hit_way, miss_count, output ready);
endinterface

// ===== design/set_assoc_lru_cache.sv =====
// set_assoc_lru_cache: one request at a time; its set row is read from the single-port
// set memory in the accept cycle and compared in the compare state; at commit a write
// is stored and the result made valid; commit waits while an earlier result is unread
// reset: an async low reset starts a clearing pass over all 2^SETS_LOG2 rows (64 by
// default), one set row per cycle, with ready low; config writes are taken throughout
// depends on salc_pkg, salc_in_if, salc_out_if, salc_ctrl, salc_dpath

module set_assoc_lru_cache import salc_pkg::*; #(
  parameter int unsigned SETS_LOG2   = SETS_LOG2_DEF,
  parameter int unsigned WAYS        = WAYS_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  salc_in_if.sink               in_i,
  salc_out_if.source            out_o
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W = WAY_W;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  salc_dpath #(
    .SETS_LOG2   (SETS_LOG2),
    .WAYS        (WAYS),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .WAY_W       (WAY_W),
    .AGE_W       (AGE_W)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_func_i    (in_i.func),
    .in_key_i     (in_i.key),
    .in_value_i   (in_i.value),
    .outcome_o    (out_o.outcome),
    .hit_way_o    (out_o.hit_way),
    .miss_count_o (out_o.miss_count)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

// ===== design/salc_ctrl.sv =====
// salc_ctrl: sequencing fsm of the cache (clearing pass, accept, compare and write back)
// depends on salc_pkg; drives commands into salc_dpath

module salc_ctrl import salc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.clear   = (state_q == ST_CLEAR);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit  = (state_q == ST_CMP) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd_o.capture) state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (cmd_o.commit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/salc_dpath.sv =====
// salc_dpath: set memory, config registers, way compare, lru update and result registers
// depends on salc_pkg; sequenced by salc_ctrl

module salc_dpath import salc_pkg::*; #(
  parameter int unsigned SETS_LOG2   = SETS_LOG2_DEF,
  parameter int unsigned WAYS        = WAYS_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned WAY_W       = 3,
  parameter int unsigned AGE_W       = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic                   in_func_i,
  input  logic [KEY_WIDTH-1:0]   in_key_i,
  input  logic [VALUE_WIDTH-1:0] in_value_i,
  output logic [OUTCOME_W-1:0]   outcome_o,
  output logic [WAY_W-1:0]       hit_way_o,
  output logic [COUNT_W-1:0]     miss_count_o
);

  localparam int unsigned NSETS  = 1 << SETS_LOG2;
  localparam int unsigned SET_AW = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
  localparam int unsigned KX_W   = (KEY_WIDTH > SET_AW) ? KEY_WIDTH : SET_AW;
  localparam int unsigned KW_W   = WAYS_CFG_W + 1;
  localparam logic [AGE_W-1:0]  AGE_TOP  = AGE_W'(WAYS - 1);
  localparam logic [SET_AW-1:0] SET_LAST = SET_AW'(NSETS - 1);
  localparam logic [3:0]        SB_MAX   = 4'(SETS_LOG2);
  localparam logic [KW_W-1:0]   KW_MAX   = KW_W'(WAYS);

  // set memory, one row per set
  logic [WAYS-1:0]                  mem_valid [NSETS];
  logic [WAYS-1:0][AGE_W-1:0]       mem_age   [NSETS];
  logic [WAYS-1:0][KEY_WIDTH-1:0]   mem_key   [NSETS];
  logic [WAYS-1:0][VALUE_WIDTH-1:0] mem_val   [NSETS];

  logic [WAYS-1:0]                  rd_valid_q;
  logic [WAYS-1:0][AGE_W-1:0]       rd_age_q;
  logic [WAYS-1:0][KEY_WIDTH-1:0]   rd_key_q;
  logic [WAYS-1:0][VALUE_WIDTH-1:0] rd_val_q;

  logic [WAYS-1:0]                  wr_valid;
  logic [WAYS-1:0][AGE_W-1:0]       wr_age;
  logic [WAYS-1:0][KEY_WIDTH-1:0]   wr_key;
  logic [WAYS-1:0][VALUE_WIDTH-1:0] wr_val;
  logic                             mem_we;
  logic [SET_AW-1:0]                mem_waddr;

  logic [SET_BITS_W-1:0]  set_bits_q;
  logic [WAYS_CFG_W-1:0]  ways_q;
  logic [SET_AW-1:0]      clr_addr_q;
  logic [COUNT_W-1:0]     cnt_q;
  logic                   func_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [SET_AW-1:0]      set_q;
  logic [OUTCOME_W-1:0]   outcome_q;
  logic [WAY_W-1:0]       hit_way_q;

  logic [3:0]        sb_eff;
  logic [KW_W-1:0]   kw;
  logic [KX_W-1:0]   key_x;
  logic [SET_AW-1:0] in_set;

  logic [WAYS-1:0]      in_use;
  logic [WAYS-1:0]      match;
  logic                 hit;
  logic [WAY_W-1:0]     found;
  logic                 has_free;
  logic [WAY_W-1:0]     first_free;
  logic [WAY_W-1:0]     victim;
  logic [AGE_W-1:0]     best;
  logic [WAY_W-1:0]     target;
  logic [AGE_W-1:0]     pivot;
  logic                 is_write;
  logic [OUTCOME_W-1:0] outcome;

  // set select from the incoming key
  always_comb begin
    sb_eff = ({1'b0, set_bits_q} > SB_MAX) ? SB_MAX : {1'b0, set_bits_q};
    key_x  = KX_W'(in_key_i);
    for (int b = 0; b < SET_AW; b++) begin
      in_set[b] = key_x[b] && (4'(b) < sb_eff);
    end
  end

  // effective associativity
  always_comb begin
    if (ways_q == '0) begin
      kw = KW_W'(1);
    end else if ({1'b0, ways_q} > KW_MAX) begin
      kw = KW_MAX;
    end else begin
      kw = {1'b0, ways_q};
    end
  end

  // way compare, free way and victim search
  always_comb begin
    hit        = 1'b0;
    found      = '0;
    has_free   = 1'b0;
    first_free = '0;
    victim     = '0;
    best       = '0;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (KW_W'(w) < kw);
      match[w]  = in_use[w] && rd_valid_q[w] && (rd_key_q[w] == key_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit   = 1'b1;
        found = WAY_W'(w);
      end
      if (in_use[w] && !rd_valid_q[w]) begin
        has_free   = 1'b1;
        first_free = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w] && (rd_age_q[w] > best)) begin
        best   = rd_age_q[w];
        victim = WAY_W'(w);
      end
    end
    pivot = rd_age_q[found];
    if (hit) begin
      target = found;
    end else if (has_free) begin
      target = first_free;
    end else begin
      target = victim;
    end
    if (!hit) begin
      outcome = OUT_MISS;
    end else if (rd_val_q[found] == value_q) begin
      outcome = OUT_HIT;
    end else begin
      outcome = OUT_UPDATE;
    end
  end

  assign is_write = (func_e'(func_q) == FUNC_WRITE);

  // updated row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_valid[w] = rd_valid_q[w];
      wr_key[w]   = rd_key_q[w];
      wr_val[w]   = rd_val_q[w];
      wr_age[w]   = rd_age_q[w];
      if (WAY_W'(w) == target) begin
        wr_valid[w] = 1'b1;
        wr_key[w]   = key_q;
        wr_val[w]   = value_q;
        wr_age[w]   = '0;
      end else if (in_use[w] && rd_valid_q[w] && (!hit || (rd_age_q[w] < pivot))
                   && (rd_age_q[w] < AGE_TOP)) begin
        wr_age[w] = rd_age_q[w] + AGE_W'(1);
      end
    end
    if (cmd_i.clear) begin
      wr_valid = '0;
      wr_key   = '0;
      wr_val   = '0;
      wr_age   = '0;
    end
  end

  assign mem_we    = cmd_i.clear || (cmd_i.commit && is_write);
  assign mem_waddr = cmd_i.clear ? clr_addr_q : set_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_valid[mem_waddr] <= wr_valid;
      mem_age[mem_waddr]   <= wr_age;
      mem_key[mem_waddr]   <= wr_key;
      mem_val[mem_waddr]   <= wr_val;
    end
    if (cmd_i.capture) begin
      rd_valid_q <= mem_valid[in_set];
      rd_age_q   <= mem_age[in_set];
      rd_key_q   <= mem_key[in_set];
      rd_val_q   <= mem_val[in_set];
      func_q     <= in_func_i;
      key_q      <= in_key_i;
      value_q    <= in_value_i;
      set_q      <= in_set;
    end
    if (cmd_i.commit) begin
      outcome_q <= outcome;
      hit_way_q <= hit ? found : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= SET_BITS_RST;
      ways_q     <= WAYS_RST;
      clr_addr_q <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SET_BITS: set_bits_q <= cfg_data_i[SET_BITS_W-1:0];
          CFG_WAYS:     ways_q     <= cfg_data_i[WAYS_CFG_W-1:0];
          default:      ;
        endcase
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + SET_AW'(1);
      end
      if (cmd_i.commit && is_write && !hit && (cnt_q != '1)) begin
        cnt_q <= cnt_q + COUNT_W'(1);
      end
    end
  end

  assign status_o.clear_last = (clr_addr_q == SET_LAST);
  assign outcome_o           = outcome_q;
  assign hit_way_o           = hit_way_q;
  assign miss_count_o        = cnt_q;

endmodule

// ===== tb/tb_set_assoc_lru_cache.sv =====
// tb_set_assoc_lru_cache: self-checking bench for the set-associative lru cache, with an
// in-bench model of the set store, ages and miss counter, random idling and a long result stall
// depends on salc_pkg, salc_in_if, salc_out_if and set_assoc_lru_cache
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache;
  import salc_pkg::*;

  localparam int unsigned NSETS      = 1 << SETS_LOG2_DEF;
  localparam int unsigned NWAYS      = WAYS_DEF;
  localparam int unsigned NLINES     = NSETS * NWAYS;
  localparam int unsigned AGE_TOP    = NWAYS - 1;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned LONG_HOLD  = 300;

  typedef struct packed {
    func_e       func;
    logic [31:0] key;
    logic [31:0] value;
  } access_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [2:0]  way;
    logic [31:0] misses;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  salc_in_if  req_if ();
  salc_out_if rsp_if ();

  set_assoc_lru_cache i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  access_t  pending_accesses[$];
  verdict_t predicted_verdicts[$];

  logic [31:0] line_key [NLINES];
  logic [31:0] line_val [NLINES];
  bit          line_ok  [NLINES];
  int unsigned line_age [NLINES];
  logic [31:0] miss_total;
  logic [2:0]  set_bits_reg;
  logic [3:0]  ways_reg;

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_reqs;
  int unsigned hold_served;
  bit          quiet;

  logic [31:0] key_pool [32];
  int unsigned pool_n;

  // classify one access against the set and apply the lru update on a write
  function automatic verdict_t cache_access(access_t a);
    int unsigned sb, kw, set_no, base, ix, found, target, best, pivot;
    bit hit, every;
    verdict_t v;
    sb = (set_bits_reg > SETS_LOG2_DEF) ? SETS_LOG2_DEF : set_bits_reg;
    kw = (ways_reg == 0) ? 1 : ((ways_reg > NWAYS) ? NWAYS : ways_reg);
    set_no = a.key & ((32'd1 << sb) - 32'd1);
    base = set_no * NWAYS;
    hit = 1'b0;
    found = 0;
    v.outcome = OUT_MISS;
    for (int unsigned w = 0; w < kw; w++) begin
      ix = base + w;
      if (!hit && line_ok[ix] && line_key[ix] == a.key) begin
        hit = 1'b1;
        found = w;
        v.outcome = (line_val[ix] == a.value) ? OUT_HIT : OUT_UPDATE;
      end
    end
    if (a.func == FUNC_WRITE) begin
      if (hit) begin
        target = found;
        every = 1'b0;
        pivot = line_age[base + found];
      end else begin
        target = kw;
        every = 1'b1;
        pivot = 0;
        for (int unsigned w = 0; w < kw; w++)
          if (target == kw && !line_ok[base + w]) target = w;
        if (target == kw) begin
          best = 0;
          target = 0;
          for (int unsigned w = 0; w < kw; w++) begin
            if (line_age[base + w] > best) begin
              best = line_age[base + w];
              target = w;
            end
          end
        end
      end
      for (int unsigned w = 0; w < kw; w++) begin
        ix = base + w;
        if (w != target && line_ok[ix] && (every || line_age[ix] < pivot) &&
            line_age[ix] < AGE_TOP)
          line_age[ix]++;
      end
      ix = base + target;
      line_key[ix] = a.key;
      line_val[ix] = a.value;
      line_ok[ix]  = 1'b1;
      line_age[ix] = 0;
      if (!hit && miss_total != 32'hFFFF_FFFF) miss_total++;
    end
    v.way = hit ? found[2:0] : 3'd0;
    v.misses = miss_total;
    return v;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        predicted_verdicts.push_back(cache_access(pending_accesses[0]));
        void'(pending_accesses.pop_front());
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_accesses.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          req_if.valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          req_if.valid <= 1'b1;
          req_if.func  <= pending_accesses[0].func;
          req_if.key   <= pending_accesses[0].key;
          req_if.value <= pending_accesses[0].value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: outcome %0d way %0d misses %0d",
                     rsp_if.outcome, rsp_if.hit_way, rsp_if.miss_count);
        end else begin
          exp_v = predicted_verdicts.pop_front();
          if (rsp_if.outcome !== exp_v.outcome || rsp_if.hit_way !== exp_v.way ||
              rsp_if.miss_count !== exp_v.misses) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected outcome %0d way %0d misses %0d, got %0d %0d %0d",
                       exp_v.outcome, exp_v.way, exp_v.misses,
                       rsp_if.outcome, rsp_if.hit_way, rsp_if.miss_count);
          end
        end
      end
      if (hold_reqs != hold_served) begin
        hold_served++;
        stall_left = LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_cfg(input cfg_idx_e idx, input logic [3:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_SET_BITS) set_bits_reg = data[2:0];
    else ways_reg = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_access(input func_e f, input logic [31:0] k, input logic [31:0] v);
    access_t a;
    a.func  = f;
    a.key   = k;
    a.value = v;
    pending_accesses.push_back(a);
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() != 0 || predicted_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random accesses, mostly over a small key pool packed into the first few sets
  task automatic random_phase(input logic [2:0] sb, input logic [3:0] kw, input int n,
                              input bit long_hold);
    func_e f;
    logic [31:0] k, v;
    wait_idle();
    set_cfg(CFG_SET_BITS, {1'b0, sb});
    set_cfg(CFG_WAYS, kw);
    pool_n = $urandom_range(4, 24);
    for (int i = 0; i < pool_n; i++) key_pool[i] = ($urandom << 6) | $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 3) == 0) ? FUNC_LOOKUP : FUNC_WRITE;
      if ($urandom_range(0, 6) == 0) begin
        k = $urandom;
        v = $urandom;
      end else begin
        k = key_pool[$urandom_range(0, pool_n - 1)];
        v = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom;
      end
      push_access(f, k, v);
    end
    if (long_hold) hold_reqs++;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_SET_BITS;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.func  = FUNC_WRITE;
    req_if.key   = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    send_gap     = 0;
    stall_left   = 0;
    hold_reqs    = 0;
    hold_served  = 0;
    quiet        = 1'b0;
    miss_total   = '0;
    set_bits_reg = SET_BITS_RST;
    ways_reg     = WAYS_RST;
    for (int i = 0; i < NLINES; i++) begin
      line_key[i] = '0;
      line_val[i] = '0;
      line_ok[i]  = 1'b0;
      line_age[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one set, three ways: fill, update, evict the lru line
    set_cfg(CFG_SET_BITS, 4'd0);
    set_cfg(CFG_WAYS, 4'd3);
    push_access(FUNC_LOOKUP, 32'h0, 32'h0);
    push_access(FUNC_WRITE, 32'h0, 32'h0);
    push_access(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_access(FUNC_LOOKUP, 32'h0, 32'h0);
    push_access(FUNC_LOOKUP, 32'h0, 32'hFFFF_FFFF);
    push_access(FUNC_WRITE, 32'hFFFF_FFFF, 32'h0);
    push_access(FUNC_WRITE, 32'h1234, 32'h5);
    push_access(FUNC_WRITE, 32'h5555, 32'h6);
    push_access(FUNC_WRITE, 32'h1234, 32'h5);
    push_access(FUNC_LOOKUP, 32'h5555, 32'h7);
    wait_idle();

    // zero ways acts as one: upper lines hidden, key lands twice in the set
    set_cfg(CFG_WAYS, 4'd0);
    push_access(FUNC_WRITE, 32'h1234, 32'h9);
    push_access(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    wait_idle();

    // ways above the maximum: hidden lines come back, lowest duplicate wins
    set_cfg(CFG_WAYS, 4'd15);
    push_access(FUNC_LOOKUP, 32'h1234, 32'h9);
    push_access(FUNC_WRITE, 32'h1234, 32'h1);
    push_access(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    wait_idle();

    // set bits above the maximum act as the maximum
    set_cfg(CFG_SET_BITS, 4'd7);
    set_cfg(CFG_WAYS, 4'd8);
    push_access(FUNC_WRITE, 32'hFFFF_FFFF, 32'h1);
    push_access(FUNC_WRITE, 32'h40, 32'h2);
    push_access(FUNC_LOOKUP, 32'h40, 32'h2);

    random_phase(3'd6, 4'd8, 150, 1'b0);
    random_phase(3'd2, 4'd4, 150, 1'b1);
    random_phase(3'd0, 4'd1, 100, 1'b0);
    random_phase(3'd7, 4'd15, 120, 1'b0);
    random_phase(3'd3, 4'd0, 100, 1'b0);
    random_phase(3'd5, 4'd2, 100, 1'b0);
    wait_idle();
    quiet = 1'b1;
    random_phase(3'd1, 4'd9, 150, 1'b0);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && predicted_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
